>>> src/pfsp_pkg.sv
package pfsp_pkg;

  // default sizes
  localparam int MAX_INDIVIDUALS_DEF = 256;
  localparam int MAX_GENES_DEF       = 32;
  localparam int QUEUE_DEPTH         = 4;

  // fixed field widths
  localparam int GENE_W = 7;
  localparam int SUM_W  = 12;
  localparam int CHG_W  = 19;
  localparam int FIT_W  = 20;
  localparam int QIDX_W = 8;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_ELITE = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [GENE_W-1:0] gene_value;
    logic              last_gene;
    logic [QIDX_W-1:0] query_index;
  } in_word_t;

  typedef struct packed {
    logic [QIDX_W-1:0]       individual_index;
    logic [SUM_W-1:0]        speed_total;
    logic [CHG_W-1:0]        change_total;
    logic signed [FIT_W-1:0] fitness_value;
    logic                    non_dominated;
    logic                    valid_res;
  } out_word_t;

  // command from front to back; OP_LOAD here means commit an individual
  typedef struct packed {
    logic [1:0]        op;
    logic [SUM_W-1:0]  speed_total;
    logic [CHG_W-1:0]  change_total;
    logic [QIDX_W-1:0] query_index;
  } cmd_t;

  function automatic logic signed [FIT_W-1:0] fitness(input logic [SUM_W-1:0] s,
                                                      input logic [CHG_W-1:0] c);
    fitness = $signed({{(FIT_W-SUM_W){1'b0}}, s} - {{(FIT_W-CHG_W){1'b0}}, c});
  endfunction

endpackage

>>> src/pfsp_queue.sv
module pfsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfsp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pfsp_pkg::cmd_t pop_cmd
);
  import pfsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign valid   = (fill_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/pfsp_front.sv
module pfsp_front #(
  parameter int MAX_GENES = pfsp_pkg::MAX_GENES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfsp_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               push,
  output pfsp_pkg::cmd_t     push_cmd
);
  import pfsp_pkg::*;

  localparam int GPOS_W = $clog2(MAX_GENES + 1);

  logic [GPOS_W-1:0] gpos_r, gpos_nxt;
  logic [GENE_W-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CHG_W-1:0]  chg_r, chg_nxt;

  logic              take;
  logic [GENE_W-1:0] diff;
  logic [2*GENE_W-1:0] diff_sq;
  logic [SUM_W:0]    sum_add;
  logic [CHG_W:0]    chg_add;
  logic [SUM_W-1:0]  sum_upd;
  logic [CHG_W-1:0]  chg_upd;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // gene accumulation with saturation
  always_comb begin
    diff    = (in_data.gene_value > prev_r) ? in_data.gene_value - prev_r
                                            : prev_r - in_data.gene_value;
    diff_sq = (2*GENE_W)'(diff) * (2*GENE_W)'(diff);
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(in_data.gene_value);
    chg_add = {1'b0, chg_r} + (CHG_W+1)'(diff_sq);
    sum_upd = sum_r;
    chg_upd = chg_r;
    if (gpos_r < GPOS_W'(MAX_GENES)) begin
      if (gpos_r == '0) begin
        sum_upd = SUM_W'(in_data.gene_value);
        chg_upd = '0;
      end else begin
        sum_upd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        chg_upd = chg_add[CHG_W] ? CHG_MAX : chg_add[CHG_W-1:0];
      end
    end
  end

  // classify the word and build the command
  always_comb begin
    gpos_nxt = gpos_r;
    prev_nxt = prev_r;
    sum_nxt  = sum_r;
    chg_nxt  = chg_r;
    push     = 1'b0;
    push_cmd.op           = in_data.op;
    push_cmd.speed_total  = sum_upd;
    push_cmd.change_total = chg_upd;
    push_cmd.query_index  = in_data.query_index;
    if (take) begin
      case (in_data.op)
        OP_CLEAR: begin
          push     = 1'b1;
          gpos_nxt = '0;
          prev_nxt = '0;
          sum_nxt  = '0;
          chg_nxt  = '0;
        end
        OP_LOAD: begin
          if (gpos_r < GPOS_W'(MAX_GENES)) begin
            gpos_nxt = gpos_r + 1'b1;
            prev_nxt = in_data.gene_value;
            sum_nxt  = sum_upd;
            chg_nxt  = chg_upd;
          end
          if (in_data.last_gene) begin
            push     = 1'b1;
            gpos_nxt = '0;
            prev_nxt = '0;
            sum_nxt  = '0;
            chg_nxt  = '0;
          end
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpos_r <= '0;
      prev_r <= '0;
      sum_r  <= '0;
      chg_r  <= '0;
    end else begin
      gpos_r <= gpos_nxt;
      prev_r <= prev_nxt;
      sum_r  <= sum_nxt;
      chg_r  <= chg_nxt;
    end
  end

endmodule

>>> src/pfsp_back.sv
module pfsp_back #(
  parameter int MAX_INDIVIDUALS = pfsp_pkg::MAX_INDIVIDUALS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pfsp_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output pfsp_pkg::out_word_t out_data
);
  import pfsp_pkg::*;

  localparam int IDX_W = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
  localparam int CNT_W = $clog2(MAX_INDIVIDUALS + 1);
  localparam int ENT_W = SUM_W + CHG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TGT  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // population store
  logic [ENT_W-1:0] mem [MAX_INDIVIDUALS];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             wr_en;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic [CNT_W-1:0]        cmp_r, cmp_nxt;
  logic                    elite_r, elite_nxt;
  logic [QIDX_W-1:0]       qidx_r, qidx_nxt;
  logic [SUM_W-1:0]        tgt_sum_r, tgt_sum_nxt;
  logic [CHG_W-1:0]        tgt_chg_r, tgt_chg_nxt;
  logic                    nd_r, nd_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [SUM_W-1:0]        best_sum_r, best_sum_nxt;
  logic [CHG_W-1:0]        best_chg_r, best_chg_nxt;
  logic signed [FIT_W-1:0] best_fit_r, best_fit_nxt;
  out_word_t               res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r;
  logic                    load_out;

  logic [SUM_W-1:0]        ent_sum;
  logic [CHG_W-1:0]        ent_chg;
  logic signed [FIT_W-1:0] ent_fit;
  logic                    dominates;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry under compare
  always_comb begin
    ent_sum   = rd_data_r[ENT_W-1:CHG_W];
    ent_chg   = rd_data_r[CHG_W-1:0];
    ent_fit   = fitness(ent_sum, ent_chg);
    dominates = (ent_sum >= tgt_sum_r) && (ent_chg <= tgt_chg_r) &&
                ((ent_sum > tgt_sum_r) || (ent_chg < tgt_chg_r));
  end

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    elite_nxt     = elite_r;
    qidx_nxt      = qidx_r;
    tgt_sum_nxt   = tgt_sum_r;
    tgt_chg_nxt   = tgt_chg_r;
    nd_nxt        = nd_r;
    best_idx_nxt  = best_idx_r;
    best_sum_nxt  = best_sum_r;
    best_chg_nxt  = best_chg_r;
    best_fit_nxt  = best_fit_r;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {q_cmd.speed_total, q_cmd.change_total};
    rd_addr       = iss_r[IDX_W-1:0];
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_LOAD: begin
              if (count_r < CNT_W'(MAX_INDIVIDUALS)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              qidx_nxt = q_cmd.query_index;
              if (32'(q_cmd.query_index) >= 32'(count_r)) begin
                res_nxt                  = '0;
                res_nxt.individual_index = q_cmd.query_index;
                state_nxt                = S_DONE;
              end else begin
                rd_addr   = IDX_W'(q_cmd.query_index);
                elite_nxt = 1'b0;
                state_nxt = S_TGT;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_nxt   = '0;
                state_nxt = S_DONE;
              end else begin
                rd_addr   = '0;
                elite_nxt = 1'b1;
                cmp_nxt   = '0;
                iss_nxt   = CNT_W'(1);
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end
      S_TGT: begin
        tgt_sum_nxt = ent_sum;
        tgt_chg_nxt = ent_chg;
        nd_nxt      = 1'b1;
        rd_addr     = '0;
        cmp_nxt     = '0;
        iss_nxt     = CNT_W'(1);
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        if (elite_r) begin
          if (cmp_r == '0 || ent_fit > best_fit_r) begin
            best_idx_nxt = cmp_r[IDX_W-1:0];
            best_sum_nxt = ent_sum;
            best_chg_nxt = ent_chg;
            best_fit_nxt = ent_fit;
          end
        end else if (dominates) begin
          nd_nxt = 1'b0;
        end
        rd_addr = iss_r[IDX_W-1:0];
        iss_nxt = iss_r + 1'b1;
        cmp_nxt = iss_r;
        if (cmp_r + 1'b1 == count_r) begin
          if (elite_r) begin
            res_nxt.individual_index = QIDX_W'(best_idx_nxt);
            res_nxt.speed_total      = best_sum_nxt;
            res_nxt.change_total     = best_chg_nxt;
            res_nxt.fitness_value    = best_fit_nxt;
            res_nxt.non_dominated    = 1'b0;
          end else begin
            res_nxt.individual_index = qidx_r;
            res_nxt.speed_total      = tgt_sum_r;
            res_nxt.change_total     = tgt_chg_r;
            res_nxt.fitness_value    = fitness(tgt_sum_r, tgt_chg_r);
            res_nxt.non_dominated    = nd_nxt;
          end
          res_nxt.valid_res = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    cmp_r      <= cmp_nxt;
    elite_r    <= elite_nxt;
    qidx_r     <= qidx_nxt;
    tgt_sum_r  <= tgt_sum_nxt;
    tgt_chg_r  <= tgt_chg_nxt;
    nd_r       <= nd_nxt;
    best_idx_r <= best_idx_nxt;
    best_sum_r <= best_sum_nxt;
    best_chg_r <= best_chg_nxt;
    best_fit_r <= best_fit_nxt;
    res_r      <= res_nxt;
    if (load_out) begin
      out_data_r <= res_r;
    end
  end

  // store with one write port and one read port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

>>> src/pareto_front_speed_profiles.sv
// gene load and clear words are taken one per cycle while the command queue has room
// a dominance query reads its target, walks every stored individual, then holds its result for the output;
// an elite query walks every stored individual; empty or unloaded cases go straight to the result
// the walk reads one stored individual per cycle through the single table read port
// rst_n is synchronous, active low: counters, queue and handshake state clear,
// the population tables are not cleared and hold old data until rewritten
module pareto_front_speed_profiles #(
  parameter int MAX_INDIVIDUALS = pfsp_pkg::MAX_INDIVIDUALS_DEF,
  parameter int MAX_GENES       = pfsp_pkg::MAX_GENES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfsp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfsp_pkg::out_word_t out_data
);
  import pfsp_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // word classification and gene sums
  pfsp_front #(
    .MAX_GENES (MAX_GENES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue between front and back
  pfsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  // population store and query walks
  pfsp_back #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/tb_pareto_front_speed_profiles.sv
module tb_pareto_front_speed_profiles;
  import pfsp_pkg::*;

  localparam int ITEM_TARGET    = 1750;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 700;
  localparam int DRAIN_CYCLES   = MAX_INDIVIDUALS_DEF + 32;
  localparam int IN_W           = $bits(in_word_t);

  // receiver stall styles
  localparam int SINK_FREE   = 0;
  localparam int SINK_RANDOM = 1;
  localparam int SINK_PULSED = 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  pareto_front_speed_profiles uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // predicted population state
  int                gene_pos;
  logic [GENE_W-1:0] prev_gene;
  logic [SUM_W-1:0]  run_sum;
  logic [CHG_W-1:0]  run_chg;
  int                pop_count;
  int                peak_pop;
  logic [SUM_W-1:0]  speed_store [MAX_INDIVIDUALS_DEF];
  logic [CHG_W-1:0]  chg_store [MAX_INDIVIDUALS_DEF];

  out_word_t front_answers [$];
  int        errors;
  int        words_sent;
  int        answers_checked;
  int        burst_left;
  int        hold_request;
  int        idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected answer for one accepted word, and the state update it causes
  task automatic predict_front_answer(input in_word_t w);
    out_word_t         ans;
    logic [GENE_W-1:0] diff;
    logic [31:0]       acc;
    logic [SUM_W-1:0]  s;
    logic [CHG_W-1:0]  c;
    int                fit;
    int                best;
    int                best_fit;
    bit                beaten;
    ans = '0;
    case (w.op)
      OP_CLEAR: begin
        pop_count = 0;
        gene_pos  = 0;
        prev_gene = '0;
        run_sum   = '0;
        run_chg   = '0;
      end
      OP_LOAD: begin
        // genes past the length limit are dropped
        if (gene_pos < MAX_GENES_DEF) begin
          if (gene_pos == 0) begin
            run_sum = SUM_W'(w.gene_value);
            run_chg = '0;
          end else begin
            diff = (w.gene_value > prev_gene) ? w.gene_value - prev_gene
                                              : prev_gene - w.gene_value;
            acc = 32'(run_sum) + 32'(w.gene_value);
            run_sum = (acc > 32'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
            acc = 32'(run_chg) + 32'(diff) * 32'(diff);
            run_chg = (acc > 32'(CHG_MAX)) ? CHG_MAX : acc[CHG_W-1:0];
          end
          prev_gene = w.gene_value;
          gene_pos++;
        end
        // commit, unless the population is full
        if (w.last_gene) begin
          if (pop_count < MAX_INDIVIDUALS_DEF) begin
            speed_store[pop_count] = run_sum;
            chg_store[pop_count]   = run_chg;
            pop_count++;
            if (pop_count > peak_pop) peak_pop = pop_count;
          end
          gene_pos  = 0;
          prev_gene = '0;
          run_sum   = '0;
          run_chg   = '0;
        end
      end
      OP_QUERY: begin
        ans.individual_index = w.query_index;
        if (w.query_index < pop_count) begin
          s = speed_store[w.query_index];
          c = chg_store[w.query_index];
          beaten = 1'b0;
          for (int k = 0; k < pop_count; k++) begin
            if (k != w.query_index && speed_store[k] >= s && chg_store[k] <= c &&
                (speed_store[k] > s || chg_store[k] < c))
              beaten = 1'b1;
          end
          fit = int'(s) - int'(c);
          ans.speed_total   = s;
          ans.change_total  = c;
          ans.fitness_value = fit[FIT_W-1:0];
          ans.non_dominated = !beaten;
          ans.valid_res     = 1'b1;
        end
        front_answers.push_back(ans);
      end
      OP_ELITE: begin
        // first individual with the best speed minus change
        if (pop_count > 0) begin
          best     = 0;
          best_fit = int'(speed_store[0]) - int'(chg_store[0]);
          for (int k = 1; k < pop_count; k++) begin
            fit = int'(speed_store[k]) - int'(chg_store[k]);
            if (fit > best_fit) begin
              best_fit = fit;
              best     = k;
            end
          end
          ans.individual_index = best[QIDX_W-1:0];
          ans.speed_total      = speed_store[best];
          ans.change_total     = chg_store[best];
          ans.fitness_value    = best_fit[FIT_W-1:0];
          ans.valid_res        = 1'b1;
        end
        front_answers.push_back(ans);
      end
    endcase
  endtask

  // unused fields carry random bits
  function automatic in_word_t make_word(input logic [1:0] op, input int gene, input bit last,
                                         input int idx);
    in_word_t w;
    w.op          = op;
    w.gene_value  = (op == OP_LOAD) ? gene[GENE_W-1:0] : GENE_W'($urandom_range(0, 127));
    w.last_gene   = (op == OP_LOAD) ? last : 1'($urandom_range(0, 1));
    w.query_index = (op == OP_QUERY) ? idx[QIDX_W-1:0] : QIDX_W'($urandom_range(0, 255));
    return w;
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    predict_front_answer(w);
  endtask

  // one speed profile of the given length, extremes mixed in
  task automatic send_profile(input int len);
    int g;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       g = 0;
        1:       g = 127;
        default: g = $urandom_range(0, 127);
      endcase
      send_word(make_word(OP_LOAD, g, i == len - 1, 0));
    end
  endtask

  task automatic ask_some_individual();
    int idx;
    if (pop_count > 0 && $urandom_range(0, 9) < 8) idx = $urandom_range(0, pop_count - 1);
    else if ($urandom_range(0, 1) == 0) idx = pop_count;
    else idx = $urandom_range(0, 255);
    send_word(make_word(OP_QUERY, 0, 0, idx));
  endtask

  task automatic test_empty_population();
    send_word(make_word(OP_CLEAR, 0, 0, 0));
    send_word(make_word(OP_ELITE, 0, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, 255));
  endtask

  task automatic test_gene_extremes();
    send_word(make_word(OP_LOAD, 0, 0, 0));
    send_word(make_word(OP_LOAD, 127, 0, 0));
    send_word(make_word(OP_LOAD, 0, 1, 0));
    send_word(make_word(OP_LOAD, 127, 1, 0));
    send_word(make_word(OP_LOAD, 0, 1, 0));
    for (int i = 0; i < 3; i++) send_word(make_word(OP_QUERY, 0, 0, i));
    send_word(make_word(OP_ELITE, 0, 0, 0));
  endtask

  // identical individuals must not knock each other out
  task automatic test_equal_points();
    send_word(make_word(OP_LOAD, 5, 0, 0));
    send_word(make_word(OP_LOAD, 9, 1, 0));
    send_word(make_word(OP_LOAD, 5, 0, 0));
    send_word(make_word(OP_LOAD, 9, 1, 0));
    send_word(make_word(OP_QUERY, 0, 0, 3));
    send_word(make_word(OP_QUERY, 0, 0, 4));
  endtask

  // a half-loaded individual is invisible, and a clear drops it
  task automatic test_partial_individual();
    send_word(make_word(OP_LOAD, 3, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, 5));
    send_word(make_word(OP_CLEAR, 0, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, 0));
  endtask

  // fill past capacity, then ask about both ends
  task automatic test_full_population();
    send_word(make_word(OP_CLEAR, 0, 0, 0));
    for (int i = 0; i < MAX_INDIVIDUALS_DEF + 3; i++)
      send_word(make_word(OP_LOAD, $urandom_range(0, 127), 1, 0));
    send_word(make_word(OP_QUERY, 0, 0, 255));
    send_word(make_word(OP_QUERY, 0, 0, 0));
    send_word(make_word(OP_QUERY, 0, 0, $urandom_range(1, 254)));
    send_word(make_word(OP_ELITE, 0, 0, 0));
  endtask

  // receiver holds off while queries keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    for (int i = 0; i < 10; i++) ask_some_individual();
    send_word(make_word(OP_ELITE, 0, 0, 0));
    send_word(make_word(OP_CLEAR, 0, 0, 0));
  endtask

  // mostly well-formed profiles and queries, some noise
  task automatic test_random_profiles();
    int pick;
    int len;
    in_word_t w;
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        len = $urandom_range(0, 19);
        if (len < 17) len = $urandom_range(1, 8);
        else if (len < 19) len = $urandom_range(9, 32);
        else len = $urandom_range(33, 40);
        send_profile(len);
      end else if (pick < 84) begin
        ask_some_individual();
      end else if (pick < 92) begin
        send_word(make_word(OP_ELITE, 0, 0, 0));
      end else if (pick < 94) begin
        send_word(make_word(OP_CLEAR, 0, 0, 0));
      end else begin
        w = IN_W'($urandom());
        send_word(w);
      end
    end
  endtask

  // receiver: stall styles that change at random, plus a long hold
  initial begin : result_sink
    int hold_left;
    int phase_left;
    int sink_mode;
    hold_left  = 0;
    phase_left = 0;
    sink_mode  = SINK_FREE;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          sink_mode  = $urandom_range(SINK_FREE, SINK_PULSED);
          phase_left = $urandom_range(10, 150);
        end
        phase_left--;
        case (sink_mode)
          SINK_FREE:   out_ready <= 1'b1;
          SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= (phase_left % 5 == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
    end
  endtask

  // compare each result word with the oldest expected answer
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (front_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
      end else begin
        want = front_answers.pop_front();
        check_field("individual_index", 32'(want.individual_index),
                    32'(out_data.individual_index));
        check_field("speed_total", 32'(want.speed_total), 32'(out_data.speed_total));
        check_field("change_total", 32'(want.change_total), 32'(out_data.change_total));
        check_field("fitness_value", 32'(want.fitness_value), 32'(out_data.fitness_value));
        check_field("non_dominated", 32'(want.non_dominated), 32'(out_data.non_dominated));
        check_field("valid_res", 32'(want.valid_res), 32'(out_data.valid_res));
        answers_checked++;
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pareto_front_speed_profiles: mismatch");
      $finish;
    end
  end

  // main sequence
  initial begin
    errors          = 0;
    words_sent      = 0;
    answers_checked = 0;
    burst_left      = 0;
    hold_request    = 0;
    gene_pos        = 0;
    prev_gene       = '0;
    run_sum         = '0;
    run_chg         = '0;
    pop_count       = 0;
    peak_pop        = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_population();
    test_gene_extremes();
    test_equal_points();
    test_partial_individual();
    test_full_population();
    test_backpressure();
    test_random_profiles();
    in_valid <= 1'b0;

    // let outstanding answers arrive, then watch for strays
    while (front_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d answers, largest population %0d",
             words_sent, answers_checked, peak_pop);
    $display("covered clears, overlong and overflowing loads, ties, unloaded and empty queries");
    if (errors == 0) begin
      $display("pareto_front_speed_profiles: match");
    end else begin
      $display("pareto_front_speed_profiles: mismatch");
    end
    $finish;
  end

endmodule
